[hdl/lspu_pkg.sv]
// Package for the log-domain sum/product unit: value format, command codes
// and the correction ROM contents, built at elaboration time.
// No dependencies.
package lspu_pkg;

    // Value format: signed fixed point with FRAC_BITS fraction bits
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_OPS     = 4;
    localparam int DATA_W      = NUM_OPS * VALUE_WIDTH;
    localparam int CMD_W       = 3;
    localparam int IN_USER_W   = CMD_W + NUM_OPS;
    localparam int OUT_USER_W  = 2;

    // Widened sums: pairwise sum, full product sum, max-plus-correction
    localparam int PAIR_W = VALUE_WIDTH + 1;
    localparam int SUM_W  = VALUE_WIDTH + 2;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Correction table: power-of-two depth spanning differences in [0, 16.0)
    localparam int CORR_TABLE_DEPTH = 1024;
    localparam int CORR_ADDR_W      = $clog2(CORR_TABLE_DEPTH);
    localparam int CORR_W           = FRAC_BITS;
    localparam int IDX_SHIFT        = FRAC_BITS + 4;
    localparam int IDX_FULL_W       = PAIR_W + CORR_ADDR_W;

    localparam longint unsigned ONE_Q30   = 64'd1 << 30;
    localparam longint unsigned INV_E_Q30 = 64'd395007542;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUM2     = 3'd0,
        CMD_PROD2    = 3'd1,
        CMD_PROD3    = 3'd2,
        CMD_PROD4    = 3'd3,
        CMD_SUMPROD2 = 3'd4,
        CMD_SUMPROD3 = 3'd5
    } t_cmd;

    typedef logic [CORR_W-1:0] t_corr_rom [CORR_TABLE_DEPTH];

    // Unsigned quotient, one bit per step from the top by shift and subtract
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1 + exp(-x)) at the left edge of bin idx, worked in Q30 and
    // rounded half up to FRAC_BITS
    function automatic logic [CORR_W-1:0] corr_entry(input int unsigned idx);
        longint unsigned xq;
        longint unsigned m;
        longint unsigned f;
        longint unsigned t;
        longint unsigned e;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned s;
        longint          acc;
        longint unsigned k;
        xq  = (longint'(idx) << 34) / CORR_TABLE_DEPTH;
        m   = xq >> 30;
        f   = xq & (ONE_Q30 - 64'd1);
        acc = longint'(ONE_Q30);
        t   = ONE_Q30;
        // exp(-f) by truncated Taylor series
        for (k = 1; k <= 24; k++) begin
            t = div_u64((t * f) >> 30, k);
            if (k[0])
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        e = (acc > 0) ? longint'(acc) : 64'd0;
        // times exp(-1) for each whole unit of x
        for (k = 0; k < m; k++)
            e = (e * INV_E_Q30) >> 30;
        // ln(1+e) = 2 * atanh(e / (2 + e))
        z  = div_u64(e << 30, (ONE_Q30 << 1) + e);
        z2 = (z * z) >> 30;
        p  = z;
        s  = 64'd0;
        for (k = 0; k < 20; k++) begin
            s = s + div_u64(p, 2 * k + 1);
            p = (p * z2) >> 30;
        end
        s = s << 1;
        return CORR_W'((s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    endfunction

    function automatic t_corr_rom corr_rom_init();
        t_corr_rom rom;
        for (int i = 0; i < CORR_TABLE_DEPTH; i++)
            rom[i] = corr_entry(i);
        return rom;
    endfunction

endpackage

[hdl/log_domain_sum_product_unit.sv]
// Log-domain sum/product unit: four-stage pipeline with a synchronous-read
// correction ROM. Depends on lspu_pkg (format, command codes, ROM contents).
//
// The unit takes one command with up to four log-domain operands per
// transaction and returns one result per transaction, in order. It accepts a
// new transaction every cycle unless all stages are full and the output is
// stalled; each result passes through the input stage, product/select stage,
// difference and ROM read stage and output register. The 1024 x 16
// correction ROM is read once per item through its single registered port.
// Each stage holds its item while the next stage is full and stalled, and an
// empty stage takes a new item even while a result waits at the output.
module log_domain_sum_product_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: first_operand, second_operand, third_operand, fourth_operand
    input  logic [lspu_pkg::DATA_W-1:0]       s_axis_tdata,
    // tuser: command[2:0], first_is_zero, second_is_zero, third_is_zero,
    //        fourth_is_zero
    input  logic [lspu_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: result_value
    output logic [lspu_pkg::VALUE_WIDTH-1:0]  m_axis_tdata,
    // tuser: result_is_zero, saturated
    output logic [lspu_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

    localparam int W  = lspu_pkg::VALUE_WIDTH;
    localparam int CW = lspu_pkg::CMD_W;

    localparam lspu_pkg::t_corr_rom CORR_ROM = lspu_pkg::corr_rom_init();

    // Stage enables: a stage loads when it is empty or its successor moves
    logic en1, en2, en3, en_o;
    logic r_v1, r_v2, r_v3, r_o_valid;

    assign en_o = !r_o_valid || m_axis_tready;
    assign en3  = !r_v3 || en_o;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en1)  r_v1      <= s_axis_tvalid;
            if (en2)  r_v2      <= r_v1;
            if (en3)  r_v3      <= r_v2;
            if (en_o) r_o_valid <= r_v3;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: unpack operands, mask log-zero values, pairwise sums
    // ---------------------------------------------------------------
    lspu_pkg::t_cmd              in_cmd;
    logic signed [W-1:0]         op_a, op_b, op_c, op_d;
    logic                        z_a, z_b, z_c, z_d;

    assign in_cmd = lspu_pkg::t_cmd'(s_axis_tuser[CW-1:0]);
    assign z_a    = s_axis_tuser[CW];
    assign z_b    = s_axis_tuser[CW+1];
    assign z_c    = s_axis_tuser[CW+2];
    assign z_d    = s_axis_tuser[CW+3];
    assign op_a   = z_a ? '0 : s_axis_tdata[W-1:0];
    assign op_b   = z_b ? '0 : s_axis_tdata[2*W-1:W];
    assign op_c   = z_c ? '0 : s_axis_tdata[3*W-1:2*W];
    assign op_d   = z_d ? '0 : s_axis_tdata[4*W-1:3*W];

    logic signed [lspu_pkg::PAIR_W-1:0] n_s1_p01, n_s1_p23;
    logic                               n_s1_prod_z;
    logic signed [W-1:0]                n_s1_addend;
    logic                               n_s1_addend_z;

    assign n_s1_p01 = {op_a[W-1], op_a} + {op_b[W-1], op_b};

    // Pick the upper partial sum, product zero flag and log-sum addend
    always_comb begin
        n_s1_p23      = '0;
        n_s1_prod_z   = 1'b1;
        n_s1_addend   = '0;
        n_s1_addend_z = 1'b1;
        case (in_cmd)
            lspu_pkg::CMD_SUM2: begin
                n_s1_addend   = op_b;
                n_s1_addend_z = z_b;
            end
            lspu_pkg::CMD_PROD2: begin
                n_s1_prod_z = z_a | z_b;
            end
            lspu_pkg::CMD_PROD3: begin
                n_s1_p23    = {op_c[W-1], op_c};
                n_s1_prod_z = z_a | z_b | z_c;
            end
            lspu_pkg::CMD_PROD4: begin
                n_s1_p23    = {op_c[W-1], op_c} + {op_d[W-1], op_d};
                n_s1_prod_z = z_a | z_b | z_c | z_d;
            end
            lspu_pkg::CMD_SUMPROD2: begin
                n_s1_prod_z   = z_a | z_b;
                n_s1_addend   = op_c;
                n_s1_addend_z = z_c;
            end
            lspu_pkg::CMD_SUMPROD3: begin
                n_s1_p23      = {op_c[W-1], op_c};
                n_s1_prod_z   = z_a | z_b | z_c;
                n_s1_addend   = op_d;
                n_s1_addend_z = z_d;
            end
            default: begin
                n_s1_prod_z = 1'b1;
            end
        endcase
    end

    lspu_pkg::t_cmd                     r_s1_cmd;
    logic signed [W-1:0]                r_s1_a;
    logic                               r_s1_za;
    logic signed [lspu_pkg::PAIR_W-1:0] r_s1_p01, r_s1_p23;
    logic                               r_s1_prod_z;
    logic signed [W-1:0]                r_s1_addend;
    logic                               r_s1_addend_z;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_cmd      <= in_cmd;
            r_s1_a        <= op_a;
            r_s1_za       <= z_a;
            r_s1_p01      <= n_s1_p01;
            r_s1_p23      <= n_s1_p23;
            r_s1_prod_z   <= n_s1_prod_z;
            r_s1_addend   <= n_s1_addend;
            r_s1_addend_z <= n_s1_addend_z;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: finish and clip the product, select log-sum operands
    // ---------------------------------------------------------------
    logic signed [lspu_pkg::SUM_W-1:0] prod_total;
    logic                              prod_ovf;
    logic signed [W-1:0]               prod_v;
    logic                              prod_sat;

    assign prod_total = {r_s1_p01[lspu_pkg::PAIR_W-1], r_s1_p01}
                      + {r_s1_p23[lspu_pkg::PAIR_W-1], r_s1_p23};
    // Overflow when the bits above the sign disagree with it
    assign prod_ovf   = !((prod_total[lspu_pkg::SUM_W-1:W-1] == '0) ||
                          (prod_total[lspu_pkg::SUM_W-1:W-1] == '1));
    assign prod_sat   = !r_s1_prod_z && prod_ovf;

    always_comb begin
        if (r_s1_prod_z)
            prod_v = '0;
        else if (prod_ovf)
            prod_v = prod_total[lspu_pkg::SUM_W-1] ? lspu_pkg::VAL_MIN : lspu_pkg::VAL_MAX;
        else
            prod_v = prod_total[W-1:0];
    end

    logic signed [W-1:0] n_s2_a, n_s2_b;
    logic                n_s2_za, n_s2_zb, n_s2_is_sum, n_s2_sat;

    always_comb begin
        n_s2_a      = '0;
        n_s2_za     = 1'b1;
        n_s2_b      = r_s1_addend;
        n_s2_zb     = r_s1_addend_z;
        n_s2_is_sum = 1'b0;
        n_s2_sat    = 1'b0;
        case (r_s1_cmd)
            lspu_pkg::CMD_SUM2: begin
                n_s2_a      = r_s1_a;
                n_s2_za     = r_s1_za;
                n_s2_is_sum = 1'b1;
            end
            lspu_pkg::CMD_PROD2, lspu_pkg::CMD_PROD3, lspu_pkg::CMD_PROD4: begin
                n_s2_a   = prod_v;
                n_s2_za  = r_s1_prod_z;
                n_s2_sat = prod_sat;
            end
            lspu_pkg::CMD_SUMPROD2, lspu_pkg::CMD_SUMPROD3: begin
                n_s2_a      = prod_v;
                n_s2_za     = r_s1_prod_z;
                n_s2_is_sum = 1'b1;
                n_s2_sat    = prod_sat;
            end
            default: begin
                n_s2_za = 1'b1;
            end
        endcase
    end

    logic signed [W-1:0] r_s2_a, r_s2_b;
    logic                r_s2_za, r_s2_zb, r_s2_is_sum, r_s2_sat;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_a      <= n_s2_a;
            r_s2_za     <= n_s2_za;
            r_s2_b      <= n_s2_b;
            r_s2_zb     <= n_s2_zb;
            r_s2_is_sum <= n_s2_is_sum;
            r_s2_sat    <= n_s2_sat;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: max and difference, table address, log-zero bypass
    // ---------------------------------------------------------------
    logic signed [lspu_pkg::PAIR_W-1:0]    diff_ab, diff_ba;
    logic                                  a_ge_b;
    logic [lspu_pkg::PAIR_W-1:0]           diff_mag;
    logic [lspu_pkg::IDX_FULL_W-1:0]       idx_full;
    logic [lspu_pkg::CORR_ADDR_W-1:0]      corr_addr;
    logic signed [W-1:0]                   n_s3_hi;
    logic                                  n_s3_in_range;

    assign diff_ab  = {r_s2_a[W-1], r_s2_a} - {r_s2_b[W-1], r_s2_b};
    assign diff_ba  = {r_s2_b[W-1], r_s2_b} - {r_s2_a[W-1], r_s2_a};
    assign a_ge_b   = !diff_ab[lspu_pkg::PAIR_W-1];
    assign diff_mag = a_ge_b ? diff_ab : diff_ba;
    assign n_s3_hi  = a_ge_b ? r_s2_a : r_s2_b;

    // index = (d * depth) >> (FRAC_BITS + 4)
    assign idx_full      = {diff_mag, {lspu_pkg::CORR_ADDR_W{1'b0}}} >> lspu_pkg::IDX_SHIFT;
    assign n_s3_in_range = (idx_full >> lspu_pkg::CORR_ADDR_W) == '0;
    assign corr_addr     = idx_full[lspu_pkg::CORR_ADDR_W-1:0];

    logic                n_s3_use_pass;
    logic signed [W-1:0] n_s3_pass_v;
    logic                n_s3_pass_z;

    // Products and log-zero operands skip the correction add
    always_comb begin
        n_s3_use_pass = 1'b1;
        n_s3_pass_v   = r_s2_a;
        n_s3_pass_z   = r_s2_za;
        if (!r_s2_is_sum) begin
            n_s3_pass_v = r_s2_a;
            n_s3_pass_z = r_s2_za;
        end else if (r_s2_za) begin
            n_s3_pass_v = r_s2_b;
            n_s3_pass_z = r_s2_zb;
        end else if (r_s2_zb) begin
            n_s3_pass_v = r_s2_a;
            n_s3_pass_z = r_s2_za;
        end else begin
            n_s3_use_pass = 1'b0;
        end
    end

    logic signed [W-1:0]          r_s3_hi;
    logic                         r_s3_in_range;
    logic [lspu_pkg::CORR_W-1:0]  r_s3_corr;
    logic                         r_s3_use_pass;
    logic signed [W-1:0]          r_s3_pass_v;
    logic                         r_s3_pass_z;
    logic                         r_s3_sat;

    // Correction ROM, read through a registered port
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_corr <= CORR_ROM[corr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_hi       <= n_s3_hi;
            r_s3_in_range <= n_s3_in_range;
            r_s3_use_pass <= n_s3_use_pass;
            r_s3_pass_v   <= n_s3_pass_v;
            r_s3_pass_z   <= n_s3_pass_z;
            r_s3_sat      <= r_s2_sat;
        end
    end

    // ---------------------------------------------------------------
    // Output: add correction, clip at the top of the range, register
    // ---------------------------------------------------------------
    logic [lspu_pkg::CORR_W-1:0]         corr_eff;
    logic signed [lspu_pkg::PAIR_W-1:0]  sum_hc;
    logic                                sum_ovf;
    logic signed [W-1:0]                 sum_v;
    logic signed [W-1:0]                 n_o_value;
    logic                                n_o_zero;
    logic                                n_o_sat;

    assign corr_eff  = r_s3_in_range ? r_s3_corr : '0;
    assign sum_hc    = {r_s3_hi[W-1], r_s3_hi}
                     + {{(lspu_pkg::PAIR_W - lspu_pkg::CORR_W){1'b0}}, corr_eff};
    assign sum_ovf   = sum_hc[W] != sum_hc[W-1];
    assign sum_v     = sum_ovf ? lspu_pkg::VAL_MAX : sum_hc[W-1:0];
    assign n_o_value = r_s3_use_pass ? r_s3_pass_v : sum_v;
    assign n_o_zero  = r_s3_use_pass ? r_s3_pass_z : 1'b0;
    assign n_o_sat   = r_s3_sat | (!r_s3_use_pass & sum_ovf);

    logic signed [W-1:0] r_o_value;
    logic                r_o_zero;
    logic                r_o_sat;

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_value <= n_o_value;
            r_o_zero  <= n_o_zero;
            r_o_sat   <= n_o_sat;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_value;
    assign m_axis_tuser  = {r_o_sat, r_o_zero};

endmodule

[tb/sv/lspu_result_checker.sv]
// Result checker for the log-domain sum/product unit: watches both stream
// channels, predicts each result from the accepted input and compares.
// Depends on lspu_pkg for widths and command codes.
module lspu_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel of the unit
    input  logic                              i_in_tvalid,
    input  logic                              i_in_tready,
    // tdata: first_operand, second_operand, third_operand, fourth_operand
    input  logic [lspu_pkg::DATA_W-1:0]       i_in_tdata,
    // tuser: command[2:0], first_is_zero, second_is_zero, third_is_zero,
    //        fourth_is_zero
    input  logic [lspu_pkg::IN_USER_W-1:0]    i_in_tuser,
    // output channel of the unit
    input  logic                              i_out_tvalid,
    input  logic                              i_out_tready,
    // tdata: result_value
    input  logic [lspu_pkg::VALUE_WIDTH-1:0]  i_out_tdata,
    // tuser: result_is_zero, saturated
    input  logic [lspu_pkg::OUT_USER_W-1:0]   i_out_tuser,
    output int                                o_error_count,
    output int                                o_pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import lspu_pkg::*;

    localparam longint unsigned Q30_ONE   = 64'd1 << 30;
    localparam longint unsigned Q30_INV_E = 64'd395007542;

    typedef struct {
        longint v;
        bit     z;
    } log_value_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   is_zero;
        logic                   saturated;
    } log_result_t;

    longint unsigned ln1p_exp_tbl [CORR_TABLE_DEPTH];
    log_result_t     pending_log_results [$];
    log_result_t     want;
    log_result_t     got;

    // ln(1 + exp(-x)) at the left edge of a bin, in Q30 then rounded to Q16
    function automatic longint unsigned ln1p_exp_bin(input int unsigned bin);
        longint unsigned x_q30, whole, frac, term, ex, ratio, ratio_sq, pw, series, k;
        longint          acc;
        x_q30 = (longint'(bin) << 34) / CORR_TABLE_DEPTH;
        whole = x_q30 >> 30;
        frac  = x_q30 & (Q30_ONE - 64'd1);
        acc   = longint'(Q30_ONE);
        term  = Q30_ONE;
        // exp(-frac) by a truncated Taylor series
        for (k = 1; k <= 24; k++) begin
            term = ((term * frac) >> 30) / k;
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        ex = (acc > 0) ? $unsigned(acc) : 64'd0;
        // scale by 1/e once per whole unit
        for (k = 0; k < whole; k++)
            ex = (ex * Q30_INV_E) >> 30;
        // ln(1+ex) as 2*atanh(ex/(2+ex))
        ratio    = (ex << 30) / ((Q30_ONE << 1) + ex);
        ratio_sq = (ratio * ratio) >> 30;
        pw       = ratio;
        series   = 64'd0;
        for (k = 0; k < 20; k++) begin
            series = series + pw / (2 * k + 1);
            pw     = (pw * ratio_sq) >> 30;
        end
        series = series << 1;
        return (series + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    // clip to the signed value range, flag on clipping
    function automatic longint clamp_value(input longint total, inout bit sat);
        longint top_lim;
        longint bot_lim;
        top_lim = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
        bot_lim = -top_lim - 1;
        if (total > top_lim) begin
            sat = 1'b1;
            return top_lim;
        end
        if (total < bot_lim) begin
            sat = 1'b1;
            return bot_lim;
        end
        return total;
    endfunction

    // log-product: plain sum, zero if any operand is log of zero
    function automatic log_value_t log_mult(input log_value_t ops[NUM_OPS], input int count,
                                            inout bit sat);
        log_value_t res;
        longint     total;
        res.v = 0;
        res.z = 1'b0;
        total = 0;
        for (int k = 0; k < count; k++) begin
            if (ops[k].z) begin
                res.z = 1'b1;
                return res;
            end
            total += ops[k].v;
        end
        res.v = clamp_value(total, sat);
        return res;
    endfunction

    // log-sum: max plus table correction, zero operand passes the other through
    function automatic log_value_t log_add(input log_value_t a, input log_value_t b,
                                           inout bit sat);
        log_value_t      res;
        longint          hi;
        longint          lo;
        longint unsigned diff;
        longint unsigned bin;
        longint          corr;
        if (a.z)
            return b;
        if (b.z)
            return a;
        hi   = (a.v >= b.v) ? a.v : b.v;
        lo   = (a.v >= b.v) ? b.v : a.v;
        diff = $unsigned(hi - lo);
        bin  = (diff * CORR_TABLE_DEPTH) >> (FRAC_BITS + 4);
        corr = (bin < CORR_TABLE_DEPTH) ? longint'(ln1p_exp_tbl[bin]) : 0;
        res.z = 1'b0;
        res.v = clamp_value(hi + corr, sat);
        return res;
    endfunction

    function automatic log_result_t predict_log_result(input logic [DATA_W-1:0] data,
                                                       input logic [IN_USER_W-1:0] user);
        log_value_t  ops [NUM_OPS];
        log_value_t  prod;
        log_value_t  res;
        log_result_t out;
        logic [CMD_W-1:0] cmd;
        bit          sat;
        cmd = user[CMD_W-1:0];
        sat = 1'b0;
        for (int k = 0; k < NUM_OPS; k++) begin
            ops[k].z = user[CMD_W + k];
            ops[k].v = ops[k].z ? 0 : longint'($signed(data[k*VALUE_WIDTH +: VALUE_WIDTH]));
        end
        res.v = 0;
        res.z = 1'b1;
        case (cmd)
            CMD_SUM2:     res = log_add(ops[0], ops[1], sat);
            CMD_PROD2:    res = log_mult(ops, 2, sat);
            CMD_PROD3:    res = log_mult(ops, 3, sat);
            CMD_PROD4:    res = log_mult(ops, 4, sat);
            CMD_SUMPROD2: begin
                prod = log_mult(ops, 2, sat);
                res  = log_add(prod, ops[2], sat);
            end
            CMD_SUMPROD3: begin
                prod = log_mult(ops, 3, sat);
                res  = log_add(prod, ops[3], sat);
            end
            default: ;
        endcase
        out.value     = res.z ? '0 : res.v[VALUE_WIDTH-1:0];
        out.is_zero   = res.z;
        out.saturated = sat;
        return out;
    endfunction

    // fill the correction table once
    initial begin
        o_error_count     = 0;
        o_pending_results = 0;
        for (int i = 0; i < CORR_TABLE_DEPTH; i++)
            ln1p_exp_tbl[i] = ln1p_exp_bin(i);
    end

    // queue a prediction per input transaction, check each output transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_tvalid && i_in_tready)
                pending_log_results.push_back(predict_log_result(i_in_tdata, i_in_tuser));
            if (i_out_tvalid && i_out_tready) begin
                got = {i_out_tdata, i_out_tuser[0], i_out_tuser[1]};
                if (pending_log_results.size() == 0) begin
                    $display("%0t: unexpected result value %h zero %b sat %b",
                             $time, got.value, got.is_zero, got.saturated);
                    o_error_count <= o_error_count + 1;
                end else begin
                    want = pending_log_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch: expected value %h zero %b sat %b, actual value %h zero %b sat %b",
                                 $time, want.value, want.is_zero, want.saturated,
                                 got.value, got.is_zero, got.saturated);
                        o_error_count <= o_error_count + 1;
                    end
                end
            end
        end
        o_pending_results <= pending_log_results.size();
    end

endmodule

[tb/sv/log_domain_sum_product_unit_test.sv]
// Testbench top for the log-domain sum/product unit: clock, reset, stimulus
// and verdict. Depends on lspu_pkg and lspu_result_checker.
module log_domain_sum_product_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lspu_pkg::*;

    localparam logic [CMD_W-1:0]       CMD_RSVD6    = 3'd6;
    localparam logic [CMD_W-1:0]       CMD_RSVD7    = 3'd7;
    localparam logic [VALUE_WIDTH-1:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [VALUE_WIDTH-1:0] TABLE_SPAN   = 32'h0010_0000;
    localparam int                     SPREAD       = 20 << FRAC_BITS;
    localparam int                     RANDOM_ITEMS = 1450;
    localparam int                     LIMIT_CYCLES = 300000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [DATA_W-1:0]          s_axis_tdata;
    logic [IN_USER_W-1:0]       s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [VALUE_WIDTH-1:0]     m_axis_tdata;
    logic [OUT_USER_W-1:0]      m_axis_tuser;

    int                         error_count;
    int                         pending_results;
    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         cycle_count;
    int unsigned                pick;
    int                         center;
    int                         offset;
    logic [CMD_W-1:0]           cmd;
    logic [VALUE_WIDTH-1:0]     opv [NUM_OPS];
    logic [NUM_OPS-1:0]         zf;

    always #6 i_clk = ~i_clk;

    log_domain_sum_product_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lspu_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_tvalid       (s_axis_tvalid),
        .i_in_tready       (s_axis_tready),
        .i_in_tdata        (s_axis_tdata),
        .i_in_tuser        (s_axis_tuser),
        .i_out_tvalid      (m_axis_tvalid),
        .i_out_tready      (m_axis_tready),
        .i_out_tdata       (m_axis_tdata),
        .i_out_tuser       (m_axis_tuser),
        .o_error_count     (error_count),
        .o_pending_results (pending_results)
    );

    // stall the result side at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // end the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // idle at random, then hold one transaction until it is accepted
    task automatic send_op(input logic [CMD_W-1:0] op_cmd, input logic [NUM_OPS-1:0] flags,
                           input logic [DATA_W-1:0] operands);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operands;
        s_axis_tuser  <= {flags, op_cmd};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    // mostly near a shared center so differences often land inside the table
    function automatic logic [VALUE_WIDTH-1:0] rand_operand(input int mid);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return VAL_MAX - $urandom_range(0, SPREAD);
            3:       return VAL_MIN + $urandom_range(0, SPREAD);
            default: return 32'(mid + int'($urandom_range(0, 2 * SPREAD)) - SPREAD);
        endcase
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        send_idle_pct  = 25;
        recv_idle_pct <= 70;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // log-sum corners: equal extremes, widest gap, zero operands, table edge
        send_op(CMD_SUM2, 4'b0000, {$urandom, $urandom, VAL_MAX, VAL_MAX});
        send_op(CMD_SUM2, 4'b0000, {$urandom, $urandom, VAL_MIN, VAL_MIN});
        send_op(CMD_SUM2, 4'b0000, {$urandom, $urandom, VAL_MIN, VAL_MAX});
        send_op(CMD_SUM2, 4'b0001, {$urandom, $urandom, 32'(3 * ONE_Q16), 32'hDEAD_BEEF});
        send_op(CMD_SUM2, 4'b0010, {$urandom, $urandom, 32'h1234_5678, ONE_Q16});
        send_op(CMD_SUM2, 4'b0011, {$urandom, $urandom, 32'hFFFF_FFFF, 32'h8000_0001});
        send_op(CMD_SUM2, 4'b0000, {$urandom, $urandom, 32'(TABLE_SPAN - 1), 32'h0});
        send_op(CMD_SUM2, 4'b0000, {$urandom, $urandom, TABLE_SPAN, 32'h0});
        send_op(CMD_SUM2, 4'b0000, {$urandom, $urandom, 32'(-ONE_Q16), 32'(-ONE_Q16)});

        // log-product: clipping both ways, zero operand, exact sum clipped once
        send_op(CMD_PROD2, 4'b0000, {$urandom, $urandom, VAL_MAX, VAL_MAX});
        send_op(CMD_PROD2, 4'b0000, {$urandom, $urandom, VAL_MIN, VAL_MIN});
        send_op(CMD_PROD3, 4'b0100, {$urandom, 32'h7654_3210, 32'(-2 * ONE_Q16), ONE_Q16});
        send_op(CMD_PROD4, 4'b0000, {VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX});
        send_op(CMD_PROD4, 4'b0000, {VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN});
        send_op(CMD_PROD4, 4'b0000, {VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX});
        send_op(CMD_PROD2, 4'b1111, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});

        // sum-product: saturated product passed through, zero stages, plain cases
        send_op(CMD_SUMPROD2, 4'b0100, {$urandom, $urandom, VAL_MAX, VAL_MAX});
        send_op(CMD_SUMPROD2, 4'b0101, {$urandom, $urandom, ONE_Q16, ONE_Q16});
        send_op(CMD_SUMPROD2, 4'b0010, {$urandom, ONE_Q16, ONE_Q16, ONE_Q16});
        send_op(CMD_SUMPROD2, 4'b0000, {$urandom, 32'(2 * ONE_Q16), ONE_Q16, ONE_Q16});
        send_op(CMD_SUMPROD3, 4'b0000, {32'(3 * ONE_Q16), ONE_Q16, ONE_Q16, ONE_Q16});
        send_op(CMD_SUMPROD3, 4'b0000, {VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN});
        send_op(CMD_SUMPROD3, 4'b1000, {32'h0BAD_F00D, ONE_Q16, 32'(-ONE_Q16), ONE_Q16});

        // unused command codes
        send_op(CMD_RSVD6, 4'b0000, {$urandom, $urandom, $urandom, $urandom});
        send_op(CMD_RSVD7, 4'b0000, {VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX});

        // random items over three idle patterns
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct  = 70;
                recv_idle_pct <= 25;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_idle_pct <= 0;
            end
            pick   = $urandom_range(0, 31);
            cmd    = (pick < 30) ? 3'(pick % 6) : ((pick == 30) ? CMD_RSVD6 : CMD_RSVD7);
            center = int'($urandom) >>> $urandom_range(1, 12);
            for (int k = 0; k < NUM_OPS; k++) begin
                opv[k] = rand_operand(center);
                zf[k]  = ($urandom_range(0, 7) == 0);
            end
            // place the addend close to the product half the time
            offset = int'($urandom_range(0, 2 * SPREAD)) - SPREAD;
            if (cmd == CMD_SUMPROD2 && $urandom_range(0, 1))
                opv[2] = 32'(opv[0] + opv[1] + offset);
            if (cmd == CMD_SUMPROD3 && $urandom_range(0, 1))
                opv[3] = 32'(opv[0] + opv[1] + opv[2] + offset);
            send_op(cmd, zf, {opv[3], opv[2], opv[1], opv[0]});
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then allow for stray ones
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[log_domain_sum_product_unit.f]
hdl/lspu_pkg.sv
hdl/log_domain_sum_product_unit.sv
tb/sv/lspu_result_checker.sv
tb/sv/log_domain_sum_product_unit_test.sv
